// ===== sv/htld_pkg.sv =====
// ----------------------------------------------------------------------------
// htld_pkg
// Shared codes for the Huffman tree loader and decoder: item modes, result
// kinds and the serialized tree markers.
// ----------------------------------------------------------------------------
package htld_pkg;

   typedef enum logic [1:0] {
      MODE_TREE  = 2'd0,
      MODE_BIT   = 2'd1,
      MODE_END   = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_SYMBOL       = 2'd0,
      KIND_END_OK       = 2'd1,
      KIND_END_MISMATCH = 2'd2,
      KIND_ERROR        = 2'd3
   } kind_type;

   localparam logic [7:0] MARK_INTERNAL = 8'h49;  // 'I'
   localparam logic [7:0] MARK_LEAF     = 8'h4C;  // 'L'

endpackage

// ===== sv/huffman_tree_load_and_decode.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode
// Huffman decoder for 8-bit symbols. Loads a pre-order serialized code tree,
// then walks it one code bit per word and emits decoded symbols.
// ----------------------------------------------------------------------------
// Each input word is held in the input register; its result word, if any, in the result register.
// Throughput: one input word per cycle, every mode, while the result register is not stalled by
//   rsp_tready; each code bit walks one edge through the registered read of the child tables.
// Reset clears the control state (tree empty, walk at the root), but not the top frame. The node and
//   stack tables are not cleared; they are filled by the tree load.
module huffman_tree_load_and_decode
   import htld_pkg::*;
#(
   parameter int NODE_COUNT  = 512,
   parameter int STACK_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] tree_byte, [8] code_bit, [15:9] zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] symbol
   output logic [1:0]  rsp_tuser    // [1:0] out_kind
);

   localparam int NODE_W  = $clog2(NODE_COUNT);
   localparam int CNT_W   = $clog2(NODE_COUNT + 1);
   localparam int SP_W    = $clog2(STACK_DEPTH);
   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

   typedef struct packed {
      logic [NODE_W-1:0] idx;
      logic              leaf;
      logic [7:0]        sym;
   } child_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              side;
   } frame_type;

   // input register
   logic       in_valid_ff, in_valid_in;
   mode_type   in_mode_ff;
   logic [7:0] in_byte_ff;
   logic       in_bit_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   kind_type   out_kind_ff, out_kind_in;
   logic [7:0] out_sym_ff, out_sym_in;

   // tree build and walk state
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic               await_ff, await_in;
   logic               complete_ff, complete_in;
   logic               bad_ff, bad_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   frame_type          top_ff, top_in;

   // tables
   child_type left_mem  [NODE_COUNT];
   child_type right_mem [NODE_COUNT];
   frame_type stack_mem [STACK_DEPTH];
   child_type left_q_ff, right_q_ff;
   frame_type below_q_ff;

   logic              proc;
   logic              has_res;
   kind_type          res_kind;
   logic [7:0]        res_sym;
   logic              lwe, rwe, swe;
   logic [NODE_W-1:0] child_addr;
   child_type         child_wdata;
   logic [SP_W-1:0]   stack_waddr, stack_raddr;
   frame_type         stack_wdata;
   logic [DEPTH_W-1:0] depth_m1, depth_in_m2;
   logic              fail;
   logic              is_leaf;
   logic              do_place;
   logic [NODE_W-1:0] new_node;
   child_type         step;

   assign proc       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sym_ff;
   assign rsp_tuser  = out_kind_ff;

   assign depth_m1    = depth_ff - DEPTH_W'(1);
   assign depth_in_m2 = depth_in - DEPTH_W'(2);
   assign stack_waddr = depth_m1[SP_W-1:0];
   assign stack_raddr = depth_in_m2[SP_W-1:0];
   assign new_node    = used_ff[NODE_W-1:0];
   assign step        = in_bit_ff ? right_q_ff : left_q_ff;

   always_comb begin
      depth_in    = depth_ff;
      used_in     = used_ff;
      await_in    = await_ff;
      complete_in = complete_ff;
      bad_in      = bad_ff;
      cur_in      = cur_ff;
      top_in      = top_ff;
      has_res     = 1'b0;
      res_kind    = KIND_ERROR;
      res_sym     = 8'd0;
      lwe         = 1'b0;
      rwe         = 1'b0;
      swe         = 1'b0;
      child_addr  = top_ff.node;
      child_wdata = '0;
      stack_wdata = '0;
      fail        = 1'b0;
      is_leaf     = 1'b0;
      do_place    = 1'b0;

      if (proc) begin
         unique case (in_mode_ff)
            MODE_CLEAR: begin
               depth_in    = '0;
               used_in     = '0;
               await_in    = 1'b0;
               complete_in = 1'b0;
               bad_in      = 1'b0;
               cur_in      = '0;
            end
            MODE_TREE: begin
               has_res = 1'b1;
               if (!bad_ff) begin
                  if (complete_ff) begin
                     bad_in = 1'b1;
                  end else if (await_ff) begin
                     await_in = 1'b0;
                     is_leaf  = 1'b1;
                     do_place = 1'b1;
                  end else if (in_byte_ff == MARK_LEAF) begin
                     await_in = 1'b1;
                     has_res  = 1'b0;
                  end else if (in_byte_ff == MARK_INTERNAL) begin
                     do_place = 1'b1;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
            end
            MODE_BIT: begin
               has_res = 1'b1;
               if (!bad_ff && complete_ff) begin
                  if (step.leaf) begin
                     res_kind = KIND_SYMBOL;
                     res_sym  = step.sym;
                     cur_in   = '0;
                  end else begin
                     has_res = 1'b0;
                     cur_in  = step.idx;
                  end
               end
            end
            MODE_END: begin
               has_res = 1'b1;
               if (!bad_ff && complete_ff) begin
                  res_kind = (cur_ff == '0) ? KIND_END_OK : KIND_END_MISMATCH;
                  cur_in   = '0;
               end
            end
            default: begin
               has_res = 1'b1;
            end
         endcase

         // allocate a node and hook it under the pending parent, or make it the root
         if (do_place) begin
            if (used_ff >= CNT_W'(NODE_COUNT)) begin
               fail = 1'b1;
            end else begin
               used_in = used_ff + CNT_W'(1);
               if (used_ff == '0) begin
                  if (is_leaf) begin
                     complete_in = 1'b1;
                     fail        = 1'b1;
                  end else begin
                     top_in   = '{node: '0, side: 1'b0};
                     depth_in = DEPTH_W'(1);
                  end
               end else if (depth_ff == '0) begin
                  fail = 1'b1;
               end else begin
                  child_wdata = '{idx: new_node, leaf: is_leaf,
                                  sym: is_leaf ? in_byte_ff : 8'd0};
                  lwe = !top_ff.side;
                  rwe = top_ff.side;
                  if (!top_ff.side) begin
                     if (is_leaf) begin
                        top_in.side = 1'b1;
                     end else if (depth_ff >= DEPTH_W'(STACK_DEPTH)) begin
                        fail = 1'b1;
                     end else begin
                        // spill the parent, now waiting for its right child
                        swe         = 1'b1;
                        stack_wdata = '{node: top_ff.node, side: 1'b1};
                        top_in      = '{node: new_node, side: 1'b0};
                        depth_in    = depth_ff + DEPTH_W'(1);
                     end
                  end else begin
                     if (is_leaf) begin
                        // parent done: pop
                        depth_in = depth_m1;
                        top_in   = below_q_ff;
                        if (depth_ff == DEPTH_W'(1)) begin
                           complete_in = 1'b1;
                        end
                     end else begin
                        top_in = '{node: new_node, side: 1'b0};
                     end
                  end
               end
            end
            has_res = fail;
            if (fail) begin
               bad_in = 1'b1;
            end
         end
      end

      // hold a result that is not yet taken
      if (out_valid_ff && !rsp_tready) begin
         out_valid_in = 1'b1;
         out_kind_in  = out_kind_ff;
         out_sym_in   = out_sym_ff;
      end else begin
         out_valid_in = proc && has_res;
         out_kind_in  = res_kind;
         out_sym_in   = res_sym;
      end

      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else begin
         in_valid_in = in_valid_ff && !proc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         depth_ff     <= '0;
         used_ff      <= '0;
         await_ff     <= 1'b0;
         complete_ff  <= 1'b0;
         bad_ff       <= 1'b0;
         cur_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         depth_ff     <= depth_in;
         used_ff      <= used_in;
         await_ff     <= await_in;
         complete_ff  <= complete_in;
         bad_ff       <= bad_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff <= mode_type'(req_tuser);
         in_byte_ff <= req_tdata[7:0];
         in_bit_ff  <= req_tdata[8];
      end
      out_kind_ff <= out_kind_in;
      out_sym_ff  <= out_sym_in;
      top_ff      <= top_in;
   end

   // child tables: read the entry of the next current node, forward a same-cycle write
   always_ff @(posedge clock) begin
      if (lwe) begin
         left_mem[child_addr] <= child_wdata;
      end
      if (lwe && child_addr == cur_in) begin
         left_q_ff <= child_wdata;
      end else begin
         left_q_ff <= left_mem[cur_in];
      end
   end

   always_ff @(posedge clock) begin
      if (rwe) begin
         right_mem[child_addr] <= child_wdata;
      end
      if (rwe && child_addr == cur_in) begin
         right_q_ff <= child_wdata;
      end else begin
         right_q_ff <= right_mem[cur_in];
      end
   end

   // parent stack below the top frame: keep the next frame down prefetched
   always_ff @(posedge clock) begin
      if (swe) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (swe && stack_waddr == stack_raddr) begin
         below_q_ff <= stack_wdata;
      end else begin
         below_q_ff <= stack_mem[stack_raddr];
      end
   end

endmodule

// ===== sv/htld_checker.sv =====
// ----------------------------------------------------------------------------
// htld_checker
// Port-level checks for the Huffman tree loader and decoder, bound to the
// top level.
// ----------------------------------------------------------------------------
module htld_checker
   import htld_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a waiting input word holds until it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("waiting input word changed");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // only decoded symbols carry a nonzero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_SYMBOL |-> rsp_tdata == 8'd0)
      else $error("nonzero symbol on a status word");

   // an empty result register never backs up the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result pending");

   // no result word right after reset
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result word presented out of reset");

endmodule

bind huffman_tree_load_and_decode htld_checker u_htld_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
